### rtl/ssml_pkg.sv
// ----------------------------------------------------------------------------
// ssml_pkg
// Shared constants for the SPI slave message link: store geometry, operation
// kinds and link byte codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ssml_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int POS_W       = ADDR_W + 1;

  localparam logic [POS_W-1:0] POS_FULL = POS_W'(STORE_DEPTH);

  typedef enum logic [1:0] {
    OP_MASTER = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2,
    OP_ACK    = 2'd3
  } op_t;

  localparam logic [7:0] CODE_RECEIVE = 8'hF0;
  localparam logic [7:0] CODE_SEND    = 8'hF1;
  localparam logic [7:0] CODE_ACK     = 8'hF2;
  localparam logic [7:0] CODE_NACK    = 8'hF3;
  localparam logic [7:0] CODE_READY   = 8'hF4;
  localparam logic [7:0] CODE_ERROR   = 8'hF5;
  localparam logic [7:0] CODE_END     = 8'hF6;
  localparam logic [7:0] CODE_NONE    = 8'hF7;
  localparam logic [7:0] CODE_FULL    = 8'hF8;

endpackage

`default_nettype wire

### rtl/ssml_ram.sv
// ----------------------------------------------------------------------------
// ssml_ram
// Generic single write, single read RAM with registered read and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module ssml_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/spi_slave_message_link_unit.sv
// ----------------------------------------------------------------------------
// spi_slave_message_link_unit
// Byte-level message handler of an SPI slave: receive and send sessions,
// echo checking, host access to the send and receive stores.
// ----------------------------------------------------------------------------
//  channel  | dir | tuser      | tdata
//  s_axis   | in  | [1:0] op   | [7:0] data_byte, [13:8] index, [15:14] zero
//  m_axis   | out | -          | [7:0] reply, [15:8] read_data,
//           |     |            | [16] message_ready, [23:17] received_count
//
//  One beat accepted per cycle while m_axis is not stalled; a result passes
//  through stage 1 (the registered read of the receive store) and the output register.
//  Send store words at the send and receive positions are prefetched from
//  two copies of the send store, with a bypass for a write in the same beat.
//  Reset clears the control state and, by per-entry valid bits, both stores at once, no clearing pass.
//  A stalled m_axis holds the pipe; s_axis_tready drops only when it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_slave_message_link_unit
  import ssml_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // data_byte[7:0], index[13:8], pad
  input  wire logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // reply, read_data, message_ready,
                                          // received_count
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RX   = 2'd1,
    MODE_TX   = 2'd2
  } mode_t;

  // link state
  mode_t              link_mode, link_mode_next;
  logic [POS_W-1:0]   rx_pos, rx_pos_next;
  logic [POS_W-1:0]   tx_pos, tx_pos_next;
  logic               pending, pending_next;
  logic [7:0]         tx_first, tx_first_next;
  logic [STORE_DEPTH-1:0] rx_vld;
  logic [STORE_DEPTH-1:0] tx_vld;

  // prefetch of send store at send position (a) and receive position (b)
  logic               txa_hit, txb_hit;
  logic [7:0]         txa_byp, txb_byp;
  logic               txa_vld, txb_vld;
  logic [7:0]         txa_q, txb_q;
  logic [7:0]         tx_cur, tx_chk;
  logic [ADDR_W-1:0]  txa_raddr, txb_raddr;

  // stage 1 and output register
  logic               s1_valid;
  logic [7:0]         s1_reply;
  logic               s1_read;
  logic               s1_rx_vld;
  logic               s1_pend;
  logic [POS_W-1:0]   s1_count;
  logic [7:0]         rx_q;

  logic               in_accept;
  logic               out_free;
  op_t                op;
  logic [7:0]         din;
  logic [ADDR_W-1:0]  idx;
  logic [7:0]         reply;
  logic               rx_we;
  logic               tx_we;
  logic [ADDR_W-1:0]  tx_waddr;
  logic [7:0]         tx_wdata;

  assign op        = op_t'(s_axis_tuser);
  assign din       = s_axis_tdata[7:0];
  assign idx       = s_axis_tdata[13:8];
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !s1_valid || out_free;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign tx_cur = txa_hit ? txa_byp : (txa_vld ? txa_q : 8'h00);
  assign tx_chk = txb_hit ? txb_byp : (txb_vld ? txb_q : 8'h00);

  assign txa_raddr = tx_pos_next[ADDR_W-1:0];
  assign txb_raddr = rx_pos_next[ADDR_W-1:0];

  always_comb begin
    link_mode_next = link_mode;
    rx_pos_next    = rx_pos;
    tx_pos_next    = tx_pos;
    pending_next   = pending;
    reply          = CODE_READY;
    rx_we          = 1'b0;
    tx_we          = 1'b0;
    tx_waddr       = '0;
    tx_wdata       = 8'h00;
    if (in_accept) begin
      unique case (op)
        OP_MASTER: begin
          if (!din[7]) begin
            unique case (link_mode)
              MODE_RX: begin
                if (rx_pos < POS_FULL) begin
                  rx_we       = 1'b1;
                  rx_pos_next = rx_pos + POS_W'(1);
                end else begin
                  reply          = CODE_FULL;
                  link_mode_next = MODE_IDLE;
                end
              end
              MODE_TX: begin
                if (tx_pos >= POS_FULL) begin
                  reply          = CODE_FULL;
                  link_mode_next = MODE_IDLE;
                end else if (rx_pos > tx_pos) begin
                  reply = CODE_END;
                end else if (tx_pos > POS_W'(1) && din != tx_chk) begin
                  reply          = CODE_ERROR;
                  link_mode_next = MODE_IDLE;
                end else begin
                  reply = tx_cur;
                  // echoes are checked two positions behind the send side
                  if (tx_pos > POS_W'(1)) begin
                    rx_pos_next = rx_pos + POS_W'(1);
                  end
                  if (tx_cur != 8'h00) begin
                    tx_pos_next = tx_pos + POS_W'(1);
                  end
                end
              end
              default: reply = CODE_NACK;
            endcase
          end else begin
            unique case (din) inside
              CODE_RECEIVE: begin
                link_mode_next = MODE_RX;
                rx_pos_next    = '0;
                reply          = CODE_ACK;
              end
              CODE_SEND: begin
                if (tx_first == 8'h00) begin
                  reply = CODE_NONE;
                end else begin
                  link_mode_next = MODE_TX;
                  tx_pos_next    = POS_W'(1);
                  rx_pos_next    = '0;
                  reply          = tx_first;
                end
              end
              CODE_END: begin
                if (link_mode == MODE_RX) begin
                  pending_next = 1'b1;
                end else if (link_mode == MODE_TX) begin
                  tx_we = 1'b1;  // mark send store empty
                end
                link_mode_next = MODE_IDLE;
                reply          = CODE_ACK;
              end
              CODE_ACK: reply = CODE_READY;
              CODE_ERROR, CODE_FULL: begin
                link_mode_next = MODE_IDLE;
                reply          = CODE_ACK;
              end
              default: reply = CODE_NACK;
            endcase
          end
        end
        OP_WRITE: begin
          tx_we    = 1'b1;
          tx_waddr = idx;
          tx_wdata = din;
        end
        OP_READ: ;
        OP_ACK: begin
          pending_next = 1'b0;
          rx_pos_next  = '0;
        end
        default: ;
      endcase
    end
  end

  assign tx_first_next = (tx_we && tx_waddr == '0) ? tx_wdata : tx_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode     <= MODE_IDLE;
      rx_pos        <= '0;
      tx_pos        <= '0;
      pending       <= 1'b0;
      tx_first      <= 8'h00;
      rx_vld        <= '0;
      tx_vld        <= '0;
      txa_hit       <= 1'b0;
      txb_hit       <= 1'b0;
      txa_vld       <= 1'b0;
      txb_vld       <= 1'b0;
      s1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_accept) begin
        link_mode <= link_mode_next;
        rx_pos    <= rx_pos_next;
        tx_pos    <= tx_pos_next;
        pending   <= pending_next;
        tx_first  <= tx_first_next;
        if (rx_we) begin
          rx_vld[rx_pos[ADDR_W-1:0]] <= 1'b1;
        end
        if (tx_we) begin
          tx_vld[tx_waddr] <= 1'b1;
        end
        txa_hit   <= tx_we && tx_waddr == txa_raddr;
        txb_hit   <= tx_we && tx_waddr == txb_raddr;
        txa_byp   <= tx_wdata;
        txb_byp   <= tx_wdata;
        txa_vld   <= tx_vld[txa_raddr];
        txb_vld   <= tx_vld[txb_raddr];
        s1_reply  <= reply;
        s1_read   <= op == OP_READ;
        s1_rx_vld <= rx_vld[idx];
        s1_pend   <= pending_next;
        s1_count  <= rx_pos_next;
      end
      if (s_axis_tready) begin
        s1_valid <= in_accept;
      end
      if (out_free) begin
        m_axis_tvalid <= s1_valid;
        if (s1_valid) begin
          m_axis_tdata <= {s1_count, s1_pend,
                           (s1_read && s1_rx_vld) ? rx_q : 8'h00, s1_reply};
        end
      end
    end
  end

  ssml_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_pos[ADDR_W-1:0]),
    .wdata (din),
    .re    (in_accept),
    .raddr (idx),
    .rdata (rx_q)
  );

  ssml_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_txa_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (tx_wdata),
    .re    (in_accept),
    .raddr (txa_raddr),
    .rdata (txa_q)
  );

  ssml_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_txb_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (tx_wdata),
    .re    (in_accept),
    .raddr (txb_raddr),
    .rdata (txb_q)
  );

  // send session always starts past the first byte
  a_tx_pos: assert property (@(posedge clk) disable iff (rst)
    link_mode == MODE_TX |-> tx_pos != '0)
    else $error("send mode with zero send position");

  a_rx_write_mode: assert property (@(posedge clk) disable iff (rst)
    rx_we |-> link_mode == MODE_RX && rx_pos < POS_FULL)
    else $error("receive store written outside receive session");

  a_rx_bound: assert property (@(posedge clk) disable iff (rst)
    rx_pos <= POS_FULL && tx_pos <= POS_FULL)
    else $error("store position beyond depth");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_reply))
    else $error("stage 1 beat lost under stall");

endmodule

`default_nettype wire
